// ----- rtl/core/fud_pkg.sv -----
// Shared types, byte codes and helpers for the form body decoder.
// No dependencies; imported by every module of the decoder.
`timescale 1ns / 1ps

package fud_pkg;

    typedef enum logic [2:0] {
        PH_START,
        PH_NAME,
        PH_VALUE,
        PH_HEX1,
        PH_HEX2,
        PH_DROP
    } fud_phase_t;

    localparam logic [1:0] KIND_NAME  = 2'd0;
    localparam logic [1:0] KIND_VALUE = 2'd1;
    localparam logic [1:0] KIND_END   = 2'd2;

    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_PCT   = 8'h25;
    localparam logic [7:0] CH_AMP   = 8'h26;
    localparam logic [7:0] CH_EQ    = 8'h3D;
    localparam logic [7:0] CH_SPACE = 8'h20;

    localparam logic [6:0] PAIR_LIMIT_RESET = 7'd64;

    typedef struct packed {
        logic [7:0] out_byte;
        logic [1:0] item_kind;
        logic [5:0] pair_number;
        logic       escape_error;
        logic       limit_hit;
        logic       last_result;
    } fud_result_t;

    // Results of one input item: first is sent before second.
    typedef struct packed {
        logic [1:0]  count;
        fud_result_t first;
        fud_result_t second;
    } fud_push_t;

    // Returns {valid, nibble} for an ASCII hex digit of either case.
    function automatic logic [4:0] hex_nibble(input logic [7:0] b);
        logic [7:0] d;
        logic [4:0] res;
        res = 5'b0;
        if (b >= 8'h30 && b <= 8'h39) begin
            d   = b - 8'h30;
            res = {1'b1, d[3:0]};
        end else if (b >= 8'h41 && b <= 8'h46) begin
            d   = b - 8'h37;
            res = {1'b1, d[3:0]};
        end else if (b >= 8'h61 && b <= 8'h66) begin
            d   = b - 8'h57;
            res = {1'b1, d[3:0]};
        end else begin
            d   = 8'h00;
            res = {1'b0, d[3:0]};
        end
        return res;
    endfunction

endpackage

// ----- rtl/core/fud_parse.sv -----
// Pair splitting and value decoding for one registered body byte.
// Holds the parse state and the pair limit register; uses fud_pkg.
`timescale 1ns / 1ps

module fud_parse import fud_pkg::*; #(
    parameter int MAX_PAIRS = 64
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       cfg_wr_en,
    input  logic [6:0] cfg_wr_data,
    input  logic [7:0] item_byte,
    input  logic       item_last,
    input  logic       advance,
    output fud_push_t  push
);

    localparam int CW   = $clog2(MAX_PAIRS + 1);
    localparam int CMPW = (CW > 7) ? CW : 7;

    fud_phase_t    phase_reg, phase_next;
    logic [3:0]    hn_reg, hn_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          open_reg, open_next;
    logic          err_reg, err_next;
    logic          lim_reg, lim_next;
    logic [6:0]    pair_limit_reg;

    logic [CMPW-1:0] cnt_ext, cfg_ext, max_ext, eff_limit;
    logic [4:0]      hex;
    logic            vb, close_now, d_v, e_v;
    logic [7:0]      d_byte;
    logic [1:0]      d_kind;
    fud_result_t     d_res, e_res;

    function automatic fud_result_t pack_res(input logic [7:0] b, input logic [1:0] k,
                                             input logic [CW-1:0] c, input logic er,
                                             input logic lh, input logic lr);
        logic [CW+5:0] c_ext;
        fud_result_t   r;
        c_ext          = {6'b0, c};
        r.out_byte     = b;
        r.item_kind    = k;
        r.pair_number  = c_ext[5:0];
        r.escape_error = er;
        r.limit_hit    = lh;
        r.last_result  = lr;
        return r;
    endfunction

    assign cfg_ext   = CMPW'(pair_limit_reg);
    assign max_ext   = CMPW'(MAX_PAIRS);
    assign eff_limit = (cfg_ext < max_ext) ? cfg_ext : max_ext;
    assign cnt_ext   = CMPW'(cnt_reg);
    assign hex       = hex_nibble(item_byte);

    always_comb begin
        phase_next = phase_reg;
        hn_next    = hn_reg;
        cnt_next   = cnt_reg;
        open_next  = open_reg;
        err_next   = err_reg;
        lim_next   = lim_reg;
        vb         = 1'b0;
        close_now  = 1'b0;
        d_v        = 1'b0;
        d_byte     = item_byte;
        d_kind     = KIND_NAME;
        e_v        = 1'b0;
        e_res      = '0;

        unique case (phase_reg)
            PH_START: begin
                if (item_byte != CH_AMP && item_byte != CH_EQ) begin
                    if (cnt_ext >= eff_limit) begin
                        phase_next = PH_DROP;
                        lim_next   = 1'b1;
                    end else begin
                        phase_next = PH_NAME;
                        open_next  = 1'b1;
                        d_v        = 1'b1;
                    end
                end
            end
            PH_NAME: begin
                if (item_byte == CH_EQ) begin
                    phase_next = PH_VALUE;
                end else if (item_byte == CH_AMP) begin
                    close_now = 1'b1;
                end else begin
                    d_v = 1'b1;
                end
            end
            PH_VALUE: vb = 1'b1;
            PH_HEX1: begin
                if (hex[4]) begin
                    hn_next    = hex[3:0];
                    phase_next = PH_HEX2;
                end else begin
                    // drop the escape, treat this byte as plain value data
                    err_next   = 1'b1;
                    phase_next = PH_VALUE;
                    vb         = 1'b1;
                end
            end
            PH_HEX2: begin
                phase_next = PH_VALUE;
                hn_next    = 4'h0;
                if (hex[4]) begin
                    d_v    = 1'b1;
                    d_kind = KIND_VALUE;
                    d_byte = {hn_reg, hex[3:0]};
                end else begin
                    err_next = 1'b1;
                    vb       = 1'b1;
                end
            end
            PH_DROP: begin
                if (item_byte == CH_AMP) phase_next = PH_START;
            end
            default: phase_next = PH_START;
        endcase

        if (vb) begin
            priority if (item_byte == CH_PLUS) begin
                d_v    = 1'b1;
                d_kind = KIND_VALUE;
                d_byte = CH_SPACE;
            end else if (item_byte == CH_PCT) begin
                phase_next = PH_HEX1;
            end else if (item_byte == CH_AMP) begin
                close_now = 1'b1;
            end else begin
                d_v    = 1'b1;
                d_kind = KIND_VALUE;
            end
        end

        d_res = pack_res(d_byte, d_kind, cnt_next, err_next, lim_next, 1'b0);

        if (close_now) begin
            e_v        = 1'b1;
            e_res      = pack_res(8'h00, KIND_END, cnt_next, err_next, lim_next, 1'b0);
            cnt_next   = cnt_next + CW'(1);
            phase_next = PH_START;
            open_next  = 1'b0;
        end

        if (item_last) begin
            if (phase_next == PH_HEX1 || phase_next == PH_HEX2) err_next = 1'b1;
            if (open_next) begin
                e_v   = 1'b1;
                e_res = pack_res(8'h00, KIND_END, cnt_next, err_next, lim_next, 1'b1);
            end else if (e_v) begin
                e_res.last_result = 1'b1;
            end else begin
                // body end with nothing to close: send a bare end marker
                e_v   = 1'b1;
                e_res = pack_res(8'h00, KIND_END, cnt_next, err_next, lim_next, 1'b1);
            end
            phase_next = PH_START;
            hn_next    = 4'h0;
            cnt_next   = '0;
            open_next  = 1'b0;
            err_next   = 1'b0;
            lim_next   = 1'b0;
        end

        push.count  = {1'b0, d_v} + {1'b0, e_v};
        push.first  = d_v ? d_res : e_res;
        push.second = e_res;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg      <= PH_START;
            hn_reg         <= 4'h0;
            cnt_reg        <= '0;
            open_reg       <= 1'b0;
            err_reg        <= 1'b0;
            lim_reg        <= 1'b0;
            pair_limit_reg <= PAIR_LIMIT_RESET;
        end else begin
            if (cfg_wr_en) pair_limit_reg <= cfg_wr_data;
            if (advance) begin
                phase_reg <= phase_next;
                hn_reg    <= hn_next;
                cnt_reg   <= cnt_next;
                open_reg  <= open_next;
                err_reg   <= err_next;
                lim_reg   <= lim_next;
            end
        end
    end

endmodule

// ----- rtl/core/fud_outq.sv -----
// Two-entry result queue between the parser and the output channel.
// Takes up to two results per cycle, sends one; uses fud_pkg.
`timescale 1ns / 1ps

module fud_outq import fud_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  fud_push_t   push,
    input  logic        push_en,
    input  logic        m_ready,
    output fud_result_t head,
    output logic        head_valid,
    output logic [1:0]  room
);

    fud_result_t slot0_reg, slot0_next;
    fud_result_t slot1_reg, slot1_next;
    logic [1:0]  cnt_reg, cnt_next, cnt_mid;
    logic        pop;

    assign head_valid = (cnt_reg != 2'd0);
    assign head       = slot0_reg;
    assign pop        = head_valid && m_ready;
    assign room       = 2'd2 - cnt_reg + {1'b0, pop};

    always_comb begin
        slot0_next = slot0_reg;
        slot1_next = slot1_reg;
        cnt_mid    = cnt_reg;
        if (pop) begin
            slot0_next = slot1_reg;
            cnt_mid    = cnt_reg - 2'd1;
        end
        cnt_next = cnt_mid;
        if (push_en && push.count != 2'd0) begin
            if (cnt_mid == 2'd0) slot0_next = push.first;
            else                 slot1_next = push.first;
            if (push.count == 2'd2) slot1_next = push.second;
            cnt_next = cnt_mid + push.count;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= 2'd0;
        end else begin
            cnt_reg <= cnt_next;
        end
        slot0_reg <= slot0_next;
        slot1_reg <= slot1_next;
    end

endmodule

// ----- rtl/core/form_urlencoded_decoder.sv -----
// Form body decoder: one input byte per item, name/value/end-of-pair results.
// An accepted item waits in the input register until its results enter the output queue,
// whose head drives m_axis. Throughput: 1 item per cycle while the queue has room; an item
// with two results has them sent in turn by the single-result-per-cycle output queue.
// Reset: synchronous active-low aresetn clears parse state, queue and input stage;
// pair limit returns to 64. Depends on fud_pkg, fud_parse, fud_outq.
`timescale 1ns / 1ps

module form_urlencoded_decoder import fud_pkg::*; #(
    parameter int MAX_PAIRS = 64
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [6:0]  cfg_wr_data,     // pair_limit
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,    // [7:0] in_byte
    input  logic        s_axis_tlast,    // body_end
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,    // [7:0] out_byte, [13:8] pair_number,
                                         // [14] escape_error, [15] limit_hit
    output logic [1:0]  m_axis_tuser,    // [1:0] item_kind
    output logic        m_axis_tlast     // last_result
);

    logic        in_valid_reg;
    logic [7:0]  in_byte_reg;
    logic        in_last_reg;
    logic        advance;
    logic [1:0]  room;
    fud_push_t   push;
    fud_result_t head;

    assign advance       = in_valid_reg && (push.count <= room);
    assign s_axis_tready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_axis_tready) begin
            in_valid_reg <= s_axis_tvalid;
        end
        if (s_axis_tvalid && s_axis_tready) begin
            in_byte_reg <= s_axis_tdata;
            in_last_reg <= s_axis_tlast;
        end
    end

    fud_parse #(
        .MAX_PAIRS (MAX_PAIRS)
    ) u_parse (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .item_byte   (in_byte_reg),
        .item_last   (in_last_reg),
        .advance     (advance),
        .push        (push)
    );

    fud_outq u_outq (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_en    (advance),
        .m_ready    (m_axis_tready),
        .head       (head),
        .head_valid (m_axis_tvalid),
        .room       (room)
    );

    assign m_axis_tdata = {head.limit_hit, head.escape_error, head.pair_number, head.out_byte};
    assign m_axis_tuser = head.item_kind;
    assign m_axis_tlast = head.last_result;

endmodule

// ----- rtl/core/fud_checker.sv -----
// Port-level checks for the form body decoder, bound to the top level.
// Sees only the top-level ports; uses fud_pkg for item kind codes.
`timescale 1ns / 1ps

module fud_checker import fud_pkg::*; (
    input logic        aclk,
    input logic        aresetn,
    input logic        cfg_wr_en,
    input logic [6:0]  cfg_wr_data,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic [7:0]  s_axis_tdata,
    input logic        s_axis_tlast,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [15:0] m_axis_tdata,
    input logic [1:0]  m_axis_tuser,
    input logic        m_axis_tlast
);

    logic m_fire;
    logic body_start_reg;

    assign m_fire = m_axis_tvalid && m_axis_tready;

    // set while the next result sent opens a new body
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            body_start_reg <= 1'b1;
        end else if (m_fire) begin
            body_start_reg <= m_axis_tlast;
        end
    end

    a_hold_stalled: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
        && $stable(m_axis_tuser) && $stable(m_axis_tlast))
        else $error("stalled result changed");

    a_last_on_end: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && m_axis_tlast |-> m_axis_tuser == KIND_END)
        else $error("last result is not an end of pair");

    a_end_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && m_axis_tuser == KIND_END |-> m_axis_tdata[7:0] == 8'h00)
        else $error("end of pair carries a nonzero byte");

    a_body_fresh: assert property (@(posedge aclk) disable iff (!aresetn)
        m_fire && body_start_reg |-> m_axis_tdata[13:8] == 6'd0 && !m_axis_tdata[14])
        else $error("first result of a body carries old pair state");

endmodule

bind form_urlencoded_decoder fud_checker u_fud_checker (.*);

// ----- sim/form_urlencoded_decoder_test.sv -----
// Self-checking bench for form_urlencoded_decoder: table-driven and random form bodies.
// Keeps its own decoder model and compares every result beat against it or, for directed rows, against the table.
// Depends on fud_pkg and form_urlencoded_decoder.
`timescale 1ns / 1ps

module form_urlencoded_decoder_test;
    import fud_pkg::*;

    localparam int MAX_PAIRS = 64;
    localparam logic [7:0] DIGIT_0 = 8'h30;
    localparam logic [7:0] UPPER_A = 8'h41;
    localparam logic [7:0] LOWER_A = 8'h61;
    localparam int NUM_PHASES = 7;
    localparam logic [6:0] PHASE_LIMITS [NUM_PHASES] = '{7'd1, 7'd64, 7'd2, 7'd64, 7'd3,
                                                         7'd17, 7'd5};

    typedef struct packed {
        logic [7:0] b;
        logic       last;
    } body_byte_t;

    typedef struct packed {
        logic [7:0]  b;
        logic        last;
        logic        has_want;
        fud_result_t want;
    } dir_row_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_wr_en = 1'b0;
    logic [6:0]  cfg_wr_data = 7'd0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = 8'd0;
    logic        s_axis_tlast = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [15:0] m_axis_tdata;
    logic [1:0]  m_axis_tuser;
    logic        m_axis_tlast;

    // decoder model state
    fud_phase_t  parse_phase;
    logic [3:0]  hi_nibble;
    int          pairs_taken;
    logic        pair_active;
    logic        bad_escape_seen;
    logic        pair_dropped;
    logic [6:0]  pair_limit;
    fud_result_t step_res [2];
    int          step_n;
    int          close_at;

    fud_result_t pending_results[$];
    body_byte_t  body_q[$];
    dir_row_t    directed_rows [25];

    int failures = 0;
    int bytes_sent = 0;
    int bodies_sent = 0;
    int results_checked = 0;
    int send_mode = 1;
    int sink_mode = 1;
    int hold_request = 0;

    form_urlencoded_decoder #(
        .MAX_PAIRS(MAX_PAIRS)
    ) dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    function automatic int hex_of(input logic [7:0] b);
        if (b >= DIGIT_0 && b <= DIGIT_0 + 8'd9) return int'(b - DIGIT_0);
        if (b >= UPPER_A && b <= UPPER_A + 8'd5) return int'(b - UPPER_A) + 10;
        if (b >= LOWER_A && b <= LOWER_A + 8'd5) return int'(b - LOWER_A) + 10;
        return -1;
    endfunction

    function automatic void clear_body_state();
        parse_phase     = PH_START;
        hi_nibble       = 4'd0;
        pairs_taken     = 0;
        pair_active     = 1'b0;
        bad_escape_seen = 1'b0;
        pair_dropped    = 1'b0;
    endfunction

    function automatic void push_result(input logic [7:0] b, input logic [1:0] kind);
        step_res[step_n] = '{b, kind, pairs_taken[5:0], bad_escape_seen, pair_dropped, 1'b0};
        step_n++;
    endfunction

    function automatic void close_pair();
        close_at = step_n;
        push_result(8'h00, KIND_END);
        pairs_taken++;
        parse_phase = PH_START;
        pair_active = 1'b0;
    endfunction

    function automatic void value_byte(input logic [7:0] b);
        if (b == CH_PLUS) push_result(CH_SPACE, KIND_VALUE);
        else if (b == CH_PCT) parse_phase = PH_HEX1;
        else if (b == CH_AMP) close_pair();
        else push_result(b, KIND_VALUE);
    endfunction

    // Work out the results one accepted byte causes; leaves them in step_res.
    function automatic void decode_step(input logic [7:0] b, input logic last);
        int h;
        int lim;
        step_n   = 0;
        close_at = -1;
        lim = (int'(pair_limit) < MAX_PAIRS) ? int'(pair_limit) : MAX_PAIRS;
        case (parse_phase)
            PH_START: begin
                if (b != CH_AMP && b != CH_EQ) begin
                    if (pairs_taken >= lim) begin
                        parse_phase  = PH_DROP;
                        pair_dropped = 1'b1;
                    end else begin
                        parse_phase = PH_NAME;
                        pair_active = 1'b1;
                        push_result(b, KIND_NAME);
                    end
                end
            end
            PH_NAME: begin
                if (b == CH_EQ) parse_phase = PH_VALUE;
                else if (b == CH_AMP) close_pair();
                else push_result(b, KIND_NAME);
            end
            PH_VALUE: value_byte(b);
            PH_HEX1: begin
                h = hex_of(b);
                if (h >= 0) begin
                    hi_nibble   = h[3:0];
                    parse_phase = PH_HEX2;
                end else begin
                    bad_escape_seen = 1'b1;
                    parse_phase     = PH_VALUE;
                    value_byte(b);
                end
            end
            PH_HEX2: begin
                h = hex_of(b);
                parse_phase = PH_VALUE;
                if (h >= 0) begin
                    push_result({hi_nibble, h[3:0]}, KIND_VALUE);
                end else begin
                    bad_escape_seen = 1'b1;
                    value_byte(b);
                end
                hi_nibble = 4'd0;
            end
            default: begin
                if (b == CH_AMP) parse_phase = PH_START;
            end
        endcase

        if (last) begin
            if (parse_phase == PH_HEX1 || parse_phase == PH_HEX2) bad_escape_seen = 1'b1;
            if (pair_active) begin
                close_pair();
                step_res[close_at].last_result = 1'b1;
            end else if (close_at >= 0) begin
                step_res[close_at].last_result = 1'b1;
            end else begin
                push_result(8'h00, KIND_END);
                step_res[step_n - 1].last_result = 1'b1;
            end
            clear_body_state();
        end
    endfunction

    function automatic string show(input fud_result_t r);
        return $sformatf("byte=%02h kind=%0d pair=%0d err=%0b lim=%0b last=%0b", r.out_byte,
                         r.item_kind, r.pair_number, r.escape_error, r.limit_hit,
                         r.last_result);
    endfunction

    function automatic void note_failure(input string msg);
        failures++;
        if (failures <= 10) $display("ERROR: %s", msg);
    endfunction

    function automatic int draw_wait(input int mode);
        if (mode == 0) return 0;
        if (mode == 1) return $urandom_range(0, 16);
        return ($urandom_range(0, 4) == 0) ? $urandom_range(1, 16) : 0;
    endfunction

    // ---------------- body generation ----------------

    function automatic void add_byte(input logic [7:0] b);
        body_q.push_back('{b, 1'b0});
    endfunction

    function automatic void end_body();
        if (body_q.size() == 0) add_byte(8'($urandom_range(0, 255)));
        body_q[body_q.size() - 1].last = 1'b1;
    endfunction

    function automatic logic [7:0] plain_char();
        logic [7:0] c;
        if ($urandom_range(0, 7) == 0) return 8'($urandom_range(0, 255));
        do c = 8'($urandom_range(8'h21, 8'h7E));
        while (c == CH_AMP || c == CH_EQ || c == CH_PCT || c == CH_PLUS);
        return c;
    endfunction

    function automatic logic [7:0] hex_char(input int n);
        if (n < 10) return DIGIT_0 + 8'(n);
        return ($urandom_range(0, 1) ? UPPER_A : LOWER_A) + 8'(n - 10);
    endfunction

    function automatic logic [7:0] non_hex_byte();
        logic [7:0] c;
        do c = 8'($urandom_range(0, 255));
        while (hex_of(c) >= 0);
        return c;
    endfunction

    function automatic void add_value_token();
        int r;
        r = $urandom_range(0, 19);
        if (r < 11) begin
            add_byte(plain_char());
        end else if (r < 14) begin
            add_byte(CH_PLUS);
        end else if (r < 18) begin
            add_byte(CH_PCT);
            add_byte(hex_char($urandom_range(0, 15)));
            add_byte(hex_char($urandom_range(0, 15)));
        end else if (r == 18) begin
            add_byte(CH_PCT);
            add_byte(non_hex_byte());
        end else begin
            add_byte(CH_PCT);
            add_byte(hex_char($urandom_range(0, 15)));
            add_byte(non_hex_byte());
        end
    endfunction

    function automatic void build_form_body();
        int pairs;
        int n;
        int tail;
        pairs = $urandom_range(0, 5);
        if ($urandom_range(0, 7) == 0) add_byte(CH_AMP);
        for (int i = 0; i < pairs; i++) begin
            if (i > 0) begin
                add_byte(CH_AMP);
                if ($urandom_range(0, 9) == 0) add_byte(CH_AMP);
            end
            if ($urandom_range(0, 7) == 0) add_byte(CH_EQ);
            n = $urandom_range(1, 4);
            repeat (n) add_byte(plain_char());
            if ($urandom_range(0, 7) != 0) begin
                add_byte(CH_EQ);
                n = $urandom_range(0, 5);
                repeat (n) add_value_token();
            end
        end
        // sometimes cut the body short inside an escape, or end on a separator
        tail = $urandom_range(0, 9);
        if (tail == 0) begin
            add_byte(CH_PCT);
        end else if (tail == 1) begin
            add_byte(CH_PCT);
            add_byte(hex_char($urandom_range(0, 15)));
        end else if (tail == 2) begin
            add_byte(CH_AMP);
        end
        end_body();
    endfunction

    function automatic void build_noise_body();
        int n;
        n = $urandom_range(1, 12);
        repeat (n) add_byte(8'($urandom_range(0, 255)));
        end_body();
    endfunction

    // More pairs than the largest limit, so the pair index wraps and pairs get dropped.
    function automatic void build_long_body();
        repeat (70) begin
            add_byte(8'($urandom_range(8'h61, 8'h7A)));
            add_byte(CH_AMP);
        end
        end_body();
    endfunction

    // ---------------- drivers ----------------

    // Call at a falling edge; returns at the falling edge after the item is taken.
    task automatic send_byte(input logic [7:0] b, input logic last, input logic has_want,
                             input fud_result_t want);
        int gap;
        gap = draw_wait(send_mode);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        s_axis_tlast  <= last;
        do @(posedge aclk); while (!s_axis_tready);
        decode_step(b, last);
        if (has_want) begin
            pending_results.push_back(want);
        end else begin
            for (int i = 0; i < step_n; i++) pending_results.push_back(step_res[i]);
        end
        bytes_sent++;
        @(negedge aclk);
    endtask

    task automatic send_body();
        foreach (body_q[i]) send_byte(body_q[i].b, body_q[i].last, 1'b0, '0);
        bodies_sent++;
        body_q.delete();
    endtask

    task automatic drain();
        int w;
        s_axis_tvalid <= 1'b0;
        for (w = 0; w < 20000 && pending_results.size() != 0; w++) @(negedge aclk);
        repeat (8) @(negedge aclk);
        foreach (pending_results[i])
            note_failure($sformatf("result never arrived: %s", show(pending_results[i])));
        pending_results.delete();
    endtask

    task automatic write_pair_limit(input logic [6:0] v);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(negedge aclk);
        cfg_wr_en   <= 1'b0;
        pair_limit = v;
    endtask

    // Result receiver: draws a stall per item; a pending hold request overrides it.
    initial begin : result_sink
        int w;
        @(negedge aclk);
        forever begin
            if (hold_request > 0) begin
                w = hold_request;
                hold_request = 0;
            end else begin
                w = draw_wait(sink_mode);
            end
            if (w > 0) begin
                m_axis_tready <= 1'b0;
                repeat (w) @(negedge aclk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge aclk); while (!m_axis_tvalid);
            @(negedge aclk);
        end
    end

    always @(posedge aclk) begin : check_results
        fud_result_t got;
        fud_result_t want;
        string diffs;
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            got = '{m_axis_tdata[7:0], m_axis_tuser, m_axis_tdata[13:8], m_axis_tdata[14],
                    m_axis_tdata[15], m_axis_tlast};
            results_checked++;
            if (pending_results.size() == 0) begin
                note_failure($sformatf("unexpected result: %s", show(got)));
            end else begin
                want  = pending_results.pop_front();
                diffs = "";
                if (got.out_byte !== want.out_byte) diffs = {diffs, " out_byte"};
                if (got.item_kind !== want.item_kind) diffs = {diffs, " item_kind"};
                if (got.pair_number !== want.pair_number) diffs = {diffs, " pair_number"};
                if (got.escape_error !== want.escape_error) diffs = {diffs, " escape_error"};
                if (got.limit_hit !== want.limit_hit) diffs = {diffs, " limit_hit"};
                if (got.last_result !== want.last_result) diffs = {diffs, " last_result"};
                if (diffs != "")
                    note_failure($sformatf("result %0d differs in%s: expected %s, got %s",
                                           results_checked, diffs, show(want), show(got)));
            end
        end
    end

    initial begin : main
        int phase_items;

        // name and value bytes, plus, escapes good, bad and cut short, body-end markers
        directed_rows = '{
            '{CH_AMP, 1'b0, 1'b0, '0},
            '{CH_EQ,  1'b0, 1'b0, '0},
            '{8'h00,  1'b0, 1'b1, '{8'h00, KIND_NAME, 6'd0, 1'b0, 1'b0, 1'b0}},
            '{CH_EQ,  1'b0, 1'b0, '0},
            '{CH_PLUS, 1'b0, 1'b1, '{CH_SPACE, KIND_VALUE, 6'd0, 1'b0, 1'b0, 1'b0}},
            '{CH_PCT, 1'b0, 1'b0, '0},
            '{8'h66,  1'b0, 1'b0, '0},
            '{8'h46,  1'b0, 1'b1, '{8'hFF, KIND_VALUE, 6'd0, 1'b0, 1'b0, 1'b0}},
            '{CH_PCT, 1'b0, 1'b0, '0},
            '{CH_PCT, 1'b0, 1'b0, '0},
            '{8'h34,  1'b0, 1'b0, '0},
            '{8'h31,  1'b0, 1'b0, '0},
            '{CH_PCT, 1'b0, 1'b0, '0},
            '{8'h67,  1'b0, 1'b1, '{8'h67, KIND_VALUE, 6'd0, 1'b1, 1'b0, 1'b0}},
            '{CH_PCT, 1'b0, 1'b0, '0},
            '{8'h41,  1'b0, 1'b0, '0},
            '{CH_AMP, 1'b0, 1'b1, '{8'h00, KIND_END, 6'd0, 1'b1, 1'b0, 1'b0}},
            '{CH_PLUS, 1'b0, 1'b0, '0},
            '{CH_AMP, 1'b0, 1'b0, '0},
            '{CH_PCT, 1'b0, 1'b0, '0},
            '{CH_EQ,  1'b0, 1'b0, '0},
            '{CH_PCT, 1'b0, 1'b0, '0},
            '{8'h39,  1'b1, 1'b1, '{8'h00, KIND_END, 6'd2, 1'b1, 1'b0, 1'b1}},
            '{CH_AMP, 1'b1, 1'b1, '{8'h00, KIND_END, 6'd0, 1'b0, 1'b0, 1'b1}},
            '{8'hFF,  1'b1, 1'b0, '0}
        };

        pair_limit = PAIR_LIMIT_RESET;
        clear_body_state();
        aresetn = 1'b0;
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        foreach (directed_rows[i])
            send_byte(directed_rows[i].b, directed_rows[i].last, directed_rows[i].has_want,
                      directed_rows[i].want);
        drain();

        for (int p = 0; p < NUM_PHASES; p++) begin
            write_pair_limit(PHASE_LIMITS[p]);
            phase_items = 0;
            if (p == 1 || p == 3) begin
                send_mode = 0;
                sink_mode = $urandom_range(0, 2);
                // hold the output off long enough for the block to back up its input
                if (p == 3) hold_request = 400;
                build_long_body();
                phase_items += body_q.size();
                send_body();
            end
            while (phase_items < 250) begin
                send_mode = $urandom_range(0, 2);
                sink_mode = $urandom_range(0, 2);
                if ($urandom_range(0, 6) == 0) build_noise_body();
                else build_form_body();
                phase_items += body_q.size();
                send_body();
            end
            drain();
        end

        $display("Sent %0d bytes in %0d bodies and checked %0d results,", bytes_sent,
                 bodies_sent, results_checked);
        $display("over pair limits 1 to 64 with escapes, dropped pairs and a long output stall.");
        if (failures == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

    initial begin : watchdog
        #3_000_000;
        $display("Timeout: decoder stopped making progress.");
        $display("end of test: mismatches");
        $finish;
    end

endmodule
